/* rtl/bacs_pkg.sv */
// Package for the bracket-aware comma splitter: beat structs, character
// classes, register indexes and sizing constants. No dependencies.
package bacs_pkg;

    // Offsets and the position counter (MAX_LENGTH must fit).
    localparam int unsigned OFFSET_W   = 17;
    localparam int unsigned MAX_LENGTH = 65536;
    localparam logic [OFFSET_W-1:0] MAX_POS = OFFSET_W'(MAX_LENGTH);

    // Bracket depth, signed and saturating.
    localparam int unsigned DEPTH_BITS = 8;
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = DEPTH_BITS'((2**(DEPTH_BITS-1)) - 1);
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = DEPTH_BITS'(-(2**(DEPTH_BITS-1)));

    // Queue between front and back.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    // Fixed character codes.
    localparam logic [7:0] QUOTE_CODE = 8'd34;
    localparam logic [7:0] COMMA_CODE = 8'd44;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRACKET_COUNTING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_CHAR        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_CHAR       = 2'd2;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [2:0] {
        K_OTHER,
        K_OPEN,
        K_CLOSE,
        K_QUOTE,
        K_COMMA
    } t_kind;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_string;
    } t_in_beat;

    typedef struct packed {
        logic [OFFSET_W-1:0] span_start;
        logic [OFFSET_W-1:0] span_end;
        logic                final_field;
        logic                overflow;
    } t_out_beat;

    // Classified character, passed from front to back through the queue.
    typedef struct packed {
        t_kind kind;
        logic  is_space;
        logic  eos;
    } t_cls;

endpackage

/* rtl/bacs_front.sv */
// Front of the comma splitter: configuration registers and character
// classification. Depends on bacs_pkg.
module bacs_front
    import bacs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_beat              i_beat,
    output t_cls                  o_cls
);

    logic       r_bracket_counting;
    logic [7:0] r_open_char;
    logic [7:0] r_close_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bracket_counting <= 1'b1;
            r_open_char        <= 8'd123;
            r_close_char       <= 8'd125;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BRACKET_COUNTING: r_bracket_counting <= i_cfg_data[0];
                CFG_OPEN_CHAR:        r_open_char        <= i_cfg_data[7:0];
                CFG_CLOSE_CHAR:       r_close_char       <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Brackets win over quote and comma; open wins over close.
    always_comb begin
        logic [7:0] c;
        c = i_beat.char_code;
        if (r_bracket_counting && c == r_open_char) begin
            o_cls.kind = K_OPEN;
        end else if (r_bracket_counting && c == r_close_char) begin
            o_cls.kind = K_CLOSE;
        end else if (c == QUOTE_CODE) begin
            o_cls.kind = K_QUOTE;
        end else if (c == COMMA_CODE) begin
            o_cls.kind = K_COMMA;
        end else begin
            o_cls.kind = K_OTHER;
        end
        o_cls.is_space = (c >= 8'd9 && c <= 8'd13) || c == 8'd32 || c == 8'h85 || c == 8'hA0;
        o_cls.eos      = i_beat.end_of_string;
    end

endmodule

/* rtl/bacs_fifo.sv */
// Short queue of classified characters between front and back.
// Depends on bacs_pkg.
module bacs_fifo
    import bacs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cls o_data
);

    t_cls               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic [FIFO_AW:0]   n_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

/* rtl/bacs_back.sv */
// Back of the comma splitter: position, quote, depth and field tracking,
// and the output register. Depends on bacs_pkg.
module bacs_back
    import bacs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cls_valid,
    input  t_cls      i_cls,
    output logic      o_cls_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    logic                         r_field_open;
    logic [OFFSET_W-1:0]          r_begin;
    logic                         r_quote;
    logic signed [DEPTH_BITS-1:0] r_depth;
    logic                         r_seen;
    logic [OFFSET_W-1:0]          r_first;
    logic [OFFSET_W-1:0]          r_last;
    logic [OFFSET_W-1:0]          r_pos;
    logic                         r_ovf;
    logic                         r_out_valid;
    t_out_beat                    r_out;

    logic                         n_field_open;
    logic [OFFSET_W-1:0]          n_begin;
    logic                         n_quote;
    logic signed [DEPTH_BITS-1:0] n_depth;
    logic                         n_seen;
    logic [OFFSET_W-1:0]          n_first;
    logic [OFFSET_W-1:0]          n_last;
    logic [OFFSET_W-1:0]          n_pos;
    logic                         n_ovf;
    logic                         emit;
    t_out_beat                    emit_beat;

    assign o_cls_pop   = i_cls_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    always_comb begin
        logic                split;
        logic                seen_e;
        logic [OFFSET_W-1:0] first_e;
        logic [OFFSET_W-1:0] last_e;
        logic [OFFSET_W-1:0] begin_e;
        logic [OFFSET_W:0]   end_wide;

        // position saturates at MAX_POS, so here equals r_pos
        n_ovf   = r_ovf || (r_pos == MAX_POS);
        begin_e = r_field_open ? r_begin : r_pos;
        seen_e  = r_field_open ? r_seen : 1'b0;
        n_quote = r_quote;
        n_depth = r_depth;
        split   = 1'b0;

        case (i_cls.kind)
            K_OPEN: begin
                if (!r_quote && r_depth < DEPTH_MAX) begin
                    n_depth = r_depth + DEPTH_BITS'(1);
                end
            end
            K_CLOSE: begin
                if (!r_quote && r_depth > DEPTH_MIN) begin
                    n_depth = r_depth - DEPTH_BITS'(1);
                end
            end
            K_QUOTE: n_quote = !r_quote;
            K_COMMA: split = !r_quote && (r_depth == '0);
            default: ;
        endcase

        // trimmed extent after this character, unless it splits
        n_seen  = seen_e;
        n_first = r_first;
        n_last  = r_last;
        if (!split && !i_cls.is_space) begin
            n_seen = 1'b1;
            if (!seen_e) begin
                n_first = r_pos;
            end
            n_last = r_pos;
        end

        // emit a split with the extent before, end of string with after
        if (split) begin
            seen_e  = seen_e;
            first_e = r_first;
            last_e  = r_last;
        end else begin
            seen_e  = n_seen;
            first_e = n_first;
            last_e  = n_last;
        end
        end_wide = {1'b0, last_e} + 1'b1;
        if (end_wide > {1'b0, MAX_POS}) begin
            end_wide = {1'b0, MAX_POS};
        end
        emit_beat.span_start  = seen_e ? first_e : begin_e;
        emit_beat.span_end    = seen_e ? end_wide[OFFSET_W-1:0] : begin_e;
        emit_beat.final_field = !split;
        emit_beat.overflow    = n_ovf;
        emit = split || i_cls.eos;

        n_field_open = !split;
        n_begin      = begin_e;
        n_pos        = (r_pos == MAX_POS) ? r_pos : r_pos + 1'b1;

        // restart the string after its last character
        if (i_cls.eos) begin
            n_field_open = 1'b0;
            n_begin      = '0;
            n_quote      = 1'b0;
            n_depth      = '0;
            n_seen       = 1'b0;
            n_first      = '0;
            n_last       = '0;
            n_pos        = '0;
            n_ovf        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_open <= 1'b0;
            r_begin      <= '0;
            r_quote      <= 1'b0;
            r_depth      <= '0;
            r_seen       <= 1'b0;
            r_first      <= '0;
            r_last       <= '0;
            r_pos        <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_cls_pop) begin
                r_field_open <= n_field_open;
                r_begin      <= n_begin;
                r_quote      <= n_quote;
                r_depth      <= n_depth;
                r_seen       <= n_seen;
                r_first      <= n_first;
                r_last       <= n_last;
                r_pos        <= n_pos;
                r_ovf        <= n_ovf;
                r_out_valid  <= emit;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cls_pop && emit) begin
            r_out <= emit_beat;
        end
    end

endmodule

/* rtl/bracket_aware_comma_splitter_core.sv */
// Top level of the quote- and bracket-aware comma splitter.
// Depends on bacs_pkg, bacs_front, bacs_fifo and bacs_back.
//
//  Channel | Direction | Handshake                    | Payload
//  --------+-----------+------------------------------+------------------------
//  in      | input     | i_in_valid / o_in_ready      | i_in_beat  (t_in_beat)
//  out     | output    | o_out_valid / i_out_ready    | o_out_beat (t_out_beat)
//  cfg     | input     | i_cfg_we (no wait)           | i_cfg_index, i_cfg_data
//
// One character beat is taken per cycle while o_in_ready is high; a field's
// span beat goes through the queue and then the output register after its
// closing character. The classifier writes into a four-entry queue; the
// tracker drains one entry per cycle whenever the output register is empty
// or being taken, so a stalled output fills the queue before o_in_ready
// drops. Synchronous active-low reset clears the queue, the string state
// and the output register, and restores the register defaults.
module bracket_aware_comma_splitter_core
    import bacs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_beat              i_in_beat,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_beat             o_out_beat,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cls cls_in;
    t_cls cls_out;
    logic fifo_full;
    logic fifo_valid;
    logic fifo_pop;
    logic in_take;

    // accept while the queue has room
    assign o_in_ready = !fifo_full;
    assign in_take    = i_in_valid && !fifo_full;

    bacs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_beat      (i_in_beat),
        .o_cls       (cls_in)
    );

    bacs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_take),
        .i_data  (cls_in),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_valid (fifo_valid),
        .o_data  (cls_out)
    );

    bacs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cls_valid (fifo_valid),
        .i_cls       (cls_out),
        .o_cls_pop   (fifo_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule
